/* rtl/sprite_frame_sequencer_assert.svh */
// Assertion macros for the sprite frame sequencer checker.
// Each macro expects signals named clk and arst_n where it is used.
`ifndef SPRITE_FRAME_SEQUENCER_ASSERT_SVH
`define SPRITE_FRAME_SEQUENCER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SFS_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SFS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/sfs_pkg.sv */
// Shared types and constants for the sprite frame sequencer.
// No dependencies; sfs_ctrl, the top level and the checker use this package.
package sfs_pkg;

	// Internal frame index width covers any bound frame count (up to 127 frames).
	localparam int FRAME_W     = 7;
	localparam int FRAME_OUT_W = 6;
	localparam int TICK_W      = 16;
	localparam int TOTAL_W     = 7;
	localparam int KIND_W      = 3;
	localparam int BATTLER_W   = 3;

	// Event codes carried on the kind field.
	typedef enum logic [KIND_W-1:0] {
		K_BIND    = 3'd0,
		K_UNBIND  = 3'd1,
		K_LOAD    = 3'd2,
		K_PREPARE = 3'd3,
		K_TICK    = 3'd4,
		K_QUERY   = 3'd5
	} kind_t;

	// Controller sequence states.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_DUR
	} fsm_t;

	// One battler's entry in the state memory.
	typedef struct packed {
		logic               active;
		logic               started;
		logic               complete;
		logic               interrupted;
		logic               staged;
		logic [TICK_W-1:0]  ticks;
		logic [FRAME_W-1:0] vis_frame;
		logic               vis_slot;
		logic [FRAME_W-1:0] stg_frame;
		logic               stg_slot;
		logic [TOTAL_W-1:0] length;
		logic               loops;
	} bstate_t;

	// One result word, handed from the controller to the output register.
	typedef struct packed {
		logic                   accepted;
		logic                   stage_request;
		logic                   present;
		logic [FRAME_OUT_W-1:0] frame_out;
		logic                   slot_out;
		logic                   interrupted_now;
		logic                   decoder_reset;
		logic                   done_res;
		logic [FRAME_OUT_W-1:0] shown_frame;
		logic                   was_interrupted;
		logic                   presenting;
	} result_t;

endpackage

/* rtl/sfs_ram.sv */
// Simple dual-port synchronous RAM: one write port, one read port, registered read.
// Standalone; used for the battler state and the frame duration table.
module sfs_ram #(
	parameter int W     = 16,
	parameter int DEPTH = 4,
	parameter int AW    = 2
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [W-1:0]  wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [W-1:0]  rdata
);

	logic [W-1:0] mem [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read port; the data register holds while no read is issued.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* rtl/sfs_ctrl.sv */
// Event controller: captures a word, reads the battler entry, computes the update
// and writes it back. Depends on sfs_pkg and sfs_ram.
module sfs_ctrl #(
	parameter int BATTLER_COUNT = 4,
	parameter int MAX_FRAMES    = 64
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [sfs_pkg::KIND_W-1:0]       kind,
	input  logic [sfs_pkg::BATTLER_W-1:0]    battler,
	input  logic                             can_present,
	input  logic                             stage_ok,
	input  logic [sfs_pkg::TOTAL_W-1:0]      frame_total,
	input  logic                             loop_mode,
	input  logic [sfs_pkg::FRAME_OUT_W-1:0]  frame_number,
	input  logic [sfs_pkg::TICK_W-1:0]       frame_ticks,
	input  logic                             out_free,
	output logic                             res_valid,
	output sfs_pkg::result_t                 res
);

	import sfs_pkg::*;

	localparam int SA_W     = (BATTLER_COUNT > 1) ? $clog2(BATTLER_COUNT) : 1;
	localparam int DA_DEPTH = BATTLER_COUNT * MAX_FRAMES;
	localparam int DA_W     = (DA_DEPTH > 1) ? $clog2(DA_DEPTH) : 1;
	localparam int ST_W     = $bits(bstate_t);

	fsm_t state_q, state_nxt;

	// Captured input word.
	logic [KIND_W-1:0]      kind_q;
	logic [BATTLER_W-1:0]   battler_q;
	logic                   can_q;
	logic                   sok_q;
	logic [TOTAL_W-1:0]     total_q;
	logic                   loop_q;
	logic [FRAME_OUT_W-1:0] fnum_q;
	logic [TICK_W-1:0]      fticks_q;

	// Entry valid bits: an entry never written reads as all zero.
	logic [BATTLER_COUNT-1:0] valid_q;
	logic                     vld_q;

	// Memory ports.
	logic            accept;
	logic            st_we;
	logic [ST_W-1:0] st_rdata;
	logic            dur_we;
	logic            dur_re;
	logic [DA_W-1:0] dur_waddr;
	logic [DA_W-1:0] dur_raddr;
	logic [TICK_W-1:0] dur_rdata;

	// Update computed in the execute cycle.
	bstate_t            cur;
	bstate_t            ex_nxt;
	result_t            ex_res;
	logic               ex_ok;
	logic               ex_dur_we;
	logic               need_dur;
	logic               pend;
	logic [FRAME_W-1:0] pf;
	logic               ps;
	logic [FRAME_W:0]   nxt_sum;
	logic               wrap_end;
	logic [FRAME_W-1:0] seq_f;
	logic               try_show;
	logic [FRAME_W-1:0] show_f;
	logic               show_s;

	// Held across the duration read of a presenting tick.
	bstate_t            pend_q;
	logic [FRAME_W-1:0] pf_q;
	logic               ps_q;
	bstate_t            fin;
	result_t            fin_res;
	logic               commit;

	assign accept   = in_valid && !in_stall;
	assign in_stall = (state_q != ST_IDLE);

	// Battler state memory, one entry per battler.
	sfs_ram #(
		.W     (ST_W),
		.DEPTH (BATTLER_COUNT),
		.AW    (SA_W)
	) u_state_ram (
		.clk   (clk),
		.we    (st_we),
		.waddr (SA_W'(battler_q)),
		.wdata ((state_q == ST_DUR) ? fin : ex_nxt),
		.re    (accept),
		.raddr (SA_W'(battler)),
		.rdata (st_rdata)
	);

	// Frame duration table, indexed by battler and frame.
	sfs_ram #(
		.W     (TICK_W),
		.DEPTH (DA_DEPTH),
		.AW    (DA_W)
	) u_dur_ram (
		.clk   (clk),
		.we    (dur_we),
		.waddr (dur_waddr),
		.wdata (fticks_q),
		.re    (dur_re),
		.raddr (dur_raddr),
		.rdata (dur_rdata)
	);

	assign dur_waddr = DA_W'(int'(battler_q) * MAX_FRAMES + int'(fnum_q));
	assign dur_raddr = DA_W'(int'(battler_q) * MAX_FRAMES + int'(show_f));

	// Input word capture.
	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q    <= kind;
			battler_q <= battler;
			can_q     <= can_present;
			sok_q     <= stage_ok;
			total_q   <= frame_total;
			loop_q    <= loop_mode;
			fnum_q    <= frame_number;
			fticks_q  <= frame_ticks;
		end
	end

	// Valid bits and the valid flag of the entry being read.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			vld_q   <= 1'b0;
		end else begin
			if (accept) begin
				vld_q <= (int'(battler) < BATTLER_COUNT) ? valid_q[SA_W'(battler)] : 1'b0;
			end
			if (st_we) begin
				valid_q[SA_W'(battler_q)] <= 1'b1;
			end
		end
	end

	// Shadow of the update while the duration is being read.
	always_ff @(posedge clk) begin
		if (dur_re) begin
			pend_q <= ex_nxt;
			pf_q   <= show_f;
			ps_q   <= show_s;
		end
	end

	assign cur = vld_q ? bstate_t'(st_rdata) : '0;

	// Sequence position of the next frame after the visible one.
	always_comb begin
		nxt_sum  = {1'b0, cur.vis_frame} + (FRAME_W+1)'(1);
		wrap_end = (nxt_sum >= {1'b0, cur.length});
		seq_f    = wrap_end ? '0 : nxt_sum[FRAME_W-1:0];
	end

	// Pending frame for a prepare event.
	always_comb begin
		pf = '0;
		ps = 1'b0;
		if (!cur.active || cur.complete) begin
			pend = 1'b0;
		end else if (!cur.started) begin
			pend = 1'b1;
		end else begin
			pend = (cur.ticks <= TICK_W'(1)) && (!wrap_end || cur.loops);
			pf   = seq_f;
			ps   = ~cur.vis_slot;
		end
	end

	// Execute: apply the event to the battler entry.
	always_comb begin
		ex_nxt    = cur;
		ex_res    = '0;
		ex_dur_we = 1'b0;
		try_show  = 1'b0;
		show_f    = '0;
		show_s    = 1'b0;
		need_dur  = 1'b0;
		ex_ok     = (kind_q <= K_QUERY) && (int'(battler_q) < BATTLER_COUNT);
		if (ex_ok) begin
			unique case (kind_q)
				K_BIND: begin
					if (total_q == '0 || int'(total_q) > MAX_FRAMES) begin
						ex_ok = 1'b0;
					end else begin
						ex_nxt               = '0;
						ex_nxt.length        = total_q;
						ex_nxt.loops         = loop_q;
						ex_nxt.active        = 1'b1;
						ex_res.decoder_reset = 1'b1;
					end
				end
				K_UNBIND: begin
					ex_nxt               = '0;
					ex_res.decoder_reset = 1'b1;
				end
				K_LOAD: begin
					if (int'(fnum_q) >= MAX_FRAMES) begin
						ex_ok = 1'b0;
					end else begin
						ex_dur_we = 1'b1;
					end
				end
				K_PREPARE: begin
					if (cur.active) begin
						if (!can_q || !pend) begin
							ex_nxt.staged    = 1'b0;
							ex_nxt.stg_frame = '0;
							ex_nxt.stg_slot  = 1'b0;
						end else if (!(cur.staged && cur.stg_frame == pf
								&& cur.stg_slot == ps)) begin
							ex_nxt.staged        = sok_q;
							ex_nxt.stg_frame     = sok_q ? pf : '0;
							ex_nxt.stg_slot      = sok_q ? ps : 1'b0;
							ex_res.stage_request = 1'b1;
							ex_res.frame_out     = pf[FRAME_OUT_W-1:0];
							ex_res.slot_out      = ps;
						end
					end
				end
				K_TICK: begin
					if (cur.active) begin
						if (!can_q) begin
							ex_nxt.staged    = 1'b0;
							ex_nxt.stg_frame = '0;
							ex_nxt.stg_slot  = 1'b0;
							if (cur.started) begin
								// Losing the display mid-action aborts it.
								ex_nxt                 = '0;
								ex_nxt.interrupted     = 1'b1;
								ex_res.interrupted_now = 1'b1;
								ex_res.decoder_reset   = 1'b1;
							end
						end else if (!cur.started) begin
							try_show = 1'b1;
						end else if (cur.complete) begin
							ex_nxt = cur;
						end else if (cur.ticks > TICK_W'(1)) begin
							ex_nxt.ticks = cur.ticks - TICK_W'(1);
						end else if (wrap_end && !cur.loops) begin
							// End of a one-shot action: hold the last frame.
							ex_nxt.complete  = 1'b1;
							ex_nxt.ticks     = TICK_W'(1);
							ex_nxt.staged    = 1'b0;
							ex_nxt.stg_frame = '0;
							ex_nxt.stg_slot  = 1'b0;
						end else begin
							try_show = 1'b1;
							show_f   = seq_f;
							show_s   = ~cur.vis_slot;
						end
						need_dur = try_show && cur.staged && cur.stg_frame == show_f
							&& cur.stg_slot == show_s && show_f < cur.length
							&& int'(show_f) < MAX_FRAMES;
					end
				end
				K_QUERY: begin
					ex_res.was_interrupted = cur.interrupted;
					ex_nxt.interrupted     = 1'b0;
				end
				default: begin
					ex_ok = 1'b0;
				end
			endcase
		end
		if (ex_ok) begin
			ex_res.accepted    = 1'b1;
			ex_res.done_res    = ex_nxt.complete;
			ex_res.shown_frame = ex_nxt.vis_frame[FRAME_OUT_W-1:0];
			ex_res.presenting  = ex_nxt.active && ex_nxt.started && can_q;
		end else begin
			ex_res    = '0;
			ex_dur_we = 1'b0;
			need_dur  = 1'b0;
		end
	end

	// Presentation of a staged frame once its duration is read.
	always_comb begin
		fin           = pend_q;
		fin.vis_frame = pf_q;
		fin.vis_slot  = ps_q;
		fin.ticks     = (dur_rdata == '0) ? TICK_W'(1) : dur_rdata;
		fin.started   = 1'b1;
		fin.complete  = 1'b0;
		fin.staged    = 1'b0;
		fin.stg_frame = '0;
		fin.stg_slot  = 1'b0;

		fin_res             = '0;
		fin_res.accepted    = 1'b1;
		fin_res.present     = 1'b1;
		fin_res.frame_out   = pf_q[FRAME_OUT_W-1:0];
		fin_res.slot_out    = ps_q;
		fin_res.shown_frame = pf_q[FRAME_OUT_W-1:0];
		fin_res.presenting  = fin.active && can_q;
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Next state, commit and memory strobes.
	always_comb begin
		state_nxt = state_q;
		commit    = 1'b0;
		dur_re    = 1'b0;
		st_we     = 1'b0;
		dur_we    = 1'b0;
		res       = ex_res;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_nxt = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (need_dur) begin
					dur_re    = 1'b1;
					state_nxt = ST_DUR;
				end else if (out_free) begin
					commit    = 1'b1;
					st_we     = ex_res.accepted;
					dur_we    = ex_dur_we;
					state_nxt = ST_IDLE;
				end
			end
			ST_DUR: begin
				res = fin_res;
				if (out_free) begin
					commit    = 1'b1;
					st_we     = 1'b1;
					state_nxt = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	assign res_valid = commit;

endmodule

/* rtl/sprite_frame_sequencer.sv */
// Per-battler sprite frame sequencer: one event word in, one result word out. Each event
// is captured as its battler entry is read, then updated and written back; a tick that
// presents a staged frame takes a further step because the frame duration is read from the
// duration memory once the frame is known. A finished result waits in the output register
// while the next event is taken; a stalled output holds the controller in its last step.
// Reset clears all battler entries at once through per-entry valid bits; no clearing pass.
module sprite_frame_sequencer #(
	parameter int BATTLER_COUNT = 4,
	parameter int MAX_FRAMES    = 64
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [sfs_pkg::KIND_W-1:0]       kind,
	input  logic [sfs_pkg::BATTLER_W-1:0]    battler,
	input  logic                             can_present,
	input  logic                             stage_ok,
	input  logic [sfs_pkg::TOTAL_W-1:0]      frame_total,
	input  logic                             loop_mode,
	input  logic [sfs_pkg::FRAME_OUT_W-1:0]  frame_number,
	input  logic [sfs_pkg::TICK_W-1:0]       frame_ticks,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic                             accepted,
	output logic                             stage_request,
	output logic                             present,
	output logic [sfs_pkg::FRAME_OUT_W-1:0]  frame_out,
	output logic                             slot_out,
	output logic                             interrupted_now,
	output logic                             decoder_reset,
	output logic                             done_res,
	output logic [sfs_pkg::FRAME_OUT_W-1:0]  shown_frame,
	output logic                             was_interrupted,
	output logic                             presenting
);

	import sfs_pkg::*;

	logic    out_valid_q;
	result_t res_q;
	logic    out_free;
	logic    res_valid;
	result_t res;

	assign out_free = !out_valid_q || !out_stall;

	sfs_ctrl #(
		.BATTLER_COUNT (BATTLER_COUNT),
		.MAX_FRAMES    (MAX_FRAMES)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.kind         (kind),
		.battler      (battler),
		.can_present  (can_present),
		.stage_ok     (stage_ok),
		.frame_total  (frame_total),
		.loop_mode    (loop_mode),
		.frame_number (frame_number),
		.frame_ticks  (frame_ticks),
		.out_free     (out_free),
		.res_valid    (res_valid),
		.res          (res)
	);

	// Output word valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output word payload.
	always_ff @(posedge clk) begin
		if (res_valid) begin
			res_q <= res;
		end
	end

	assign out_valid       = out_valid_q;
	assign accepted        = res_q.accepted;
	assign stage_request   = res_q.stage_request;
	assign present         = res_q.present;
	assign frame_out       = res_q.frame_out;
	assign slot_out        = res_q.slot_out;
	assign interrupted_now = res_q.interrupted_now;
	assign decoder_reset   = res_q.decoder_reset;
	assign done_res        = res_q.done_res;
	assign shown_frame     = res_q.shown_frame;
	assign was_interrupted = res_q.was_interrupted;
	assign presenting      = res_q.presenting;

endmodule

/* rtl/sfs_checker.sv */
// Port-level checks for sprite_frame_sequencer, bound to the top level below.
// Depends on sfs_pkg and the macros in sprite_frame_sequencer_assert.svh.
`include "sprite_frame_sequencer_assert.svh"

module sfs_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             in_valid,
	input logic                             in_stall,
	input logic                             out_valid,
	input logic                             out_stall,
	input logic                             accepted,
	input logic                             stage_request,
	input logic                             present,
	input logic [sfs_pkg::FRAME_OUT_W-1:0]  frame_out,
	input logic                             slot_out,
	input logic                             interrupted_now,
	input logic                             decoder_reset,
	input logic                             done_res,
	input logic [sfs_pkg::FRAME_OUT_W-1:0]  shown_frame,
	input logic                             was_interrupted,
	input logic                             presenting
);

	// An accepted word keeps the input side busy in the following cycle.
	`SFS_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "input not held busy after accept")

	// A stalled result word stays offered.
	`SFS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "result word dropped while stalled")

	// A rejected event reports nothing at all.
	`SFS_ASSERT_NOW(a_reject_zero, out_valid && !accepted, !stage_request && !present && !interrupted_now && !decoder_reset && !done_res && !was_interrupted && !presenting && frame_out == '0 && !slot_out && shown_frame == '0, "rejected event with nonzero result")

	// A presentation shows the presented frame and nothing else happens.
	`SFS_ASSERT_NOW(a_present_shape, out_valid && present, accepted && !stage_request && !interrupted_now && !decoder_reset && !done_res && presenting && shown_frame == frame_out, "inconsistent presentation result")

	// A decoder reset always leaves the battler idle.
	`SFS_ASSERT_NOW(a_reset_idle, out_valid && decoder_reset, accepted && !present && !presenting && !done_res && shown_frame == '0, "decoder reset with battler not idle")

endmodule

bind sprite_frame_sequencer sfs_checker u_sfs_checker (.*);
